[design/isd_pkg.sv]
// shared types and constants of the imu shake detector
`timescale 1ns / 1ps

package isd_pkg;

    // fixed field widths
    localparam int THR_BITS      = 24;
    localparam int DECAY_BITS    = 16;
    localparam int HOLD_BITS     = 16;
    localparam int TIME_BITS     = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;
    localparam int STATE_BITS    = 2;

    // detector state codes
    localparam logic [STATE_BITS-1:0] ST_IDLE      = 2'd0;
    localparam logic [STATE_BITS-1:0] ST_DETECTING = 2'd1;
    localparam logic [STATE_BITS-1:0] ST_TRIGGERED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DETECT    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COOLDOWN  = 2'd3;

    // configuration reset values
    localparam logic [THR_BITS-1:0]   RST_THRESHOLD = 24'd4096;
    localparam logic [DECAY_BITS-1:0] RST_DECAY     = 16'd58982;
    localparam logic [HOLD_BITS-1:0]  RST_DETECT    = 16'd300;
    localparam logic [HOLD_BITS-1:0]  RST_COOLDOWN  = 16'd2000;

    // configuration write toward the back end
    typedef struct packed {
        logic                     valid;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } cfg_wr_t;

endpackage

[design/isd_fifo.sv]
// small register queue between front and back end
`timescale 1ns / 1ps

module isd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      rd_ptr_reg;

    // status from pointer compare
    assign rd_valid = (wr_ptr_reg != rd_ptr_reg);
    assign full     = (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0])
                   && (wr_ptr_reg[AW] != rd_ptr_reg[AW]);
    assign rd_data  = mem_reg[rd_ptr_reg[AW-1:0]];

    // storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && rd_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

[design/isd_front.sv]
// front end: accepts samples, forms axis differences, marks the first sample
`timescale 1ns / 1ps

module isd_front #(
    parameter int ACCEL_BITS = 16,
    parameter int IN_W       = 88,
    parameter int Q_W        = 85
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            q_full,
    output logic            q_push,
    output logic [Q_W-1:0]  q_data
);

    import isd_pkg::*;

    localparam int D = ACCEL_BITS + 1;

    logic signed [ACCEL_BITS-1:0] x;
    logic signed [ACCEL_BITS-1:0] y;
    logic signed [ACCEL_BITS-1:0] z;
    logic [TIME_BITS-1:0]         now;
    logic                         app;
    logic signed [D-1:0]          dx;
    logic signed [D-1:0]          dy;
    logic signed [D-1:0]          dz;
    logic signed [ACCEL_BITS-1:0] prev_x_reg;
    logic signed [ACCEL_BITS-1:0] prev_y_reg;
    logic signed [ACCEL_BITS-1:0] prev_z_reg;
    logic                         have_prev_reg;
    logic                         accept;

    // unpack the item
    assign x   = s_tdata[ACCEL_BITS-1:0];
    assign y   = s_tdata[2*ACCEL_BITS-1:ACCEL_BITS];
    assign z   = s_tdata[3*ACCEL_BITS-1:2*ACCEL_BITS];
    assign now = s_tdata[3*ACCEL_BITS+TIME_BITS-1:3*ACCEL_BITS];
    assign app = s_tdata[3*ACCEL_BITS+TIME_BITS];

    // differences against the previous sample
    assign dx = D'(x) - D'(prev_x_reg);
    assign dy = D'(y) - D'(prev_y_reg);
    assign dz = D'(z) - D'(prev_z_reg);

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;
    assign q_data   = {!have_prev_reg, dx, dy, dz, now, app};

    // previous sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (accept)
        begin
            prev_x_reg    <= x;
            prev_y_reg    <= y;
            prev_z_reg    <= z;
            have_prev_reg <= 1'b1;
        end
    end

endmodule

[design/isd_back.sv]
// back end: squares, iterative root, decay, detector state machine, output register
`timescale 1ns / 1ps

module isd_back #(
    parameter int ACCEL_BITS = 16,
    parameter int LEVEL_BITS = 24,
    parameter int Q_W        = 85,
    parameter int OUT_W      = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  isd_pkg::cfg_wr_t    cfg,
    input  logic                q_valid,
    input  logic [Q_W-1:0]      q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata
);

    import isd_pkg::*;

    localparam int D    = ACCEL_BITS + 1;
    localparam int SQW  = 2 * D;
    localparam int SUMW = SQW + 2;
    localparam int RW   = SUMW / 2;
    localparam int CNTW = $clog2(RW);
    localparam int SW   = ((LEVEL_BITS > RW) ? LEVEL_BITS : RW) + 1;
    localparam int CW   = ((LEVEL_BITS + 4 > THR_BITS + 2) ? LEVEL_BITS + 4 : THR_BITS + 2);
    localparam int PW   = LEVEL_BITS + DECAY_BITS;
    localparam logic [SW-1:0] LEVEL_MAX = SW'({LEVEL_BITS{1'b1}});
    localparam logic [CNTW-1:0] ROOT_LAST = CNTW'(RW - 1);

    // sequencer codes
    localparam logic [2:0] SEQ_IDLE  = 3'd0;
    localparam logic [2:0] SEQ_SQ    = 3'd1;
    localparam logic [2:0] SEQ_ROOT  = 3'd2;
    localparam logic [2:0] SEQ_LEVEL = 3'd3;
    localparam logic [2:0] SEQ_EVAL  = 3'd4;

    // configuration
    logic [THR_BITS-1:0]   thr_reg;
    logic [DECAY_BITS-1:0] decay_reg;
    logic [HOLD_BITS-1:0]  detect_reg;
    logic [HOLD_BITS-1:0]  cooldown_reg;

    // detector state
    logic [LEVEL_BITS-1:0] level_reg;
    logic [STATE_BITS-1:0] state_reg;
    logic [TIME_BITS-1:0]  start_reg;
    logic [TIME_BITS-1:0]  cd_end_reg;

    // sequencer and datapath
    logic [2:0]            seq_reg;
    logic [1:0]            axis_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic signed [D-1:0]   dx_reg;
    logic signed [D-1:0]   dy_reg;
    logic signed [D-1:0]   dz_reg;
    logic [TIME_BITS-1:0]  time_reg;
    logic                  app_reg;
    logic [PW-1:0]         prod_reg;
    logic [SUMW-1:0]       acc_reg;
    logic [SUMW-1:0]       rad_reg;
    logic [RW+1:0]         rem_reg;
    logic [RW-1:0]         root_reg;

    // output register
    logic                  out_valid_reg;
    logic [STATE_BITS-1:0] out_state_reg;
    logic                  out_pulse_reg;
    logic [LEVEL_BITS-1:0] out_level_reg;
    logic                  out_cool_reg;

    // queue item fields
    logic                  q_first;
    logic signed [D-1:0]   q_dx;
    logic signed [D-1:0]   q_dy;
    logic signed [D-1:0]   q_dz;
    logic [TIME_BITS-1:0]  q_time;
    logic                  q_app;

    assign q_app   = q_data[0];
    assign q_time  = q_data[TIME_BITS:1];
    assign q_dz    = q_data[TIME_BITS+D:TIME_BITS+1];
    assign q_dy    = q_data[TIME_BITS+2*D:TIME_BITS+D+1];
    assign q_dx    = q_data[TIME_BITS+3*D:TIME_BITS+2*D+1];
    assign q_first = q_data[TIME_BITS+3*D+1];

    assign q_pop = (seq_reg == SEQ_IDLE) && q_valid;

    // square of the selected axis difference
    logic signed [D-1:0] d_sel;
    logic [D-1:0]        mag;
    logic [SQW-1:0]      sq;
    logic [SUMW-1:0]     acc_next;

    always_comb
    begin
        case (axis_reg)
            2'd0:    d_sel = dx_reg;
            2'd1:    d_sel = dy_reg;
            default: d_sel = dz_reg;
        endcase
        mag      = d_sel[D-1] ? D'(-d_sel) : D'(d_sel);
        sq       = SQW'(mag) * SQW'(mag);
        acc_next = acc_reg + SUMW'(sq);
    end

    // one root bit per step
    logic [RW+3:0] rem_t;
    logic [RW+3:0] trial;
    logic          take;

    always_comb
    begin
        rem_t = {rem_reg, rad_reg[SUMW-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        take  = (rem_t >= trial);
    end

    // decayed level plus root, saturated
    logic [SW-1:0]         lvl_sum;
    logic [LEVEL_BITS-1:0] lvl_sat;

    always_comb
    begin
        lvl_sum = SW'(prod_reg[PW-1:DECAY_BITS]) + SW'(root_reg);
        lvl_sat = (lvl_sum > LEVEL_MAX) ? LEVEL_BITS'(LEVEL_MAX) : lvl_sum[LEVEL_BITS-1:0];
    end

    // detector decisions on the updated level
    logic [CW-1:0]         lvl10;
    logic [CW-1:0]         thr_w;
    logic [CW-1:0]         thr3;
    logic                  cool;
    logic                  faint;
    logic                  low;
    logic                  above;
    logic                  held;
    logic [TIME_BITS-1:0]  elapsed;
    logic [STATE_BITS-1:0] st_new;
    logic [LEVEL_BITS-1:0] lvl_new;
    logic                  pulse;
    logic                  go_detect;
    logic                  go_trigger;

    always_comb
    begin
        lvl10      = (CW'(level_reg) << 3) + (CW'(level_reg) << 1);
        thr_w      = CW'(thr_reg);
        thr3       = (thr_w << 1) + thr_w;
        cool       = (time_reg < cd_end_reg);
        faint      = (lvl10 < thr_w);
        low        = (lvl10 < thr3);
        above      = (CW'(level_reg) > thr_w);
        elapsed    = time_reg - start_reg;
        held       = (elapsed >= TIME_BITS'(detect_reg));
        st_new     = state_reg;
        lvl_new    = level_reg;
        pulse      = 1'b0;
        go_detect  = 1'b0;
        go_trigger = 1'b0;
        if (cool)
        begin
            st_new = ST_IDLE;
            if (faint)
            begin
                lvl_new = '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_DETECTING:
                begin
                    if (held)
                    begin
                        st_new     = ST_TRIGGERED;
                        lvl_new    = '0;
                        pulse      = 1'b1;
                        go_trigger = 1'b1;
                    end
                    else if (low)
                    begin
                        st_new  = ST_IDLE;
                        lvl_new = '0;
                    end
                end
                ST_TRIGGERED:
                begin
                    if (app_reg)
                    begin
                        st_new  = ST_IDLE;
                        lvl_new = '0;
                    end
                end
                default:
                begin
                    st_new = ST_IDLE;
                    if (above)
                    begin
                        st_new    = ST_DETECTING;
                        go_detect = 1'b1;
                    end
                end
            endcase
        end
    end

    logic out_free;
    logic load;

    assign out_free = !out_valid_reg || m_tready;
    assign load     = (seq_reg == SEQ_EVAL) && out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= RST_THRESHOLD;
            decay_reg    <= RST_DECAY;
            detect_reg   <= RST_DETECT;
            cooldown_reg <= RST_COOLDOWN;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_THRESHOLD: thr_reg      <= cfg.data[THR_BITS-1:0];
                CFG_DECAY:     decay_reg    <= cfg.data[DECAY_BITS-1:0];
                CFG_DETECT:    detect_reg   <= cfg.data[HOLD_BITS-1:0];
                CFG_COOLDOWN:  cooldown_reg <= cfg.data[HOLD_BITS-1:0];
                default:       thr_reg      <= thr_reg;
            endcase
        end
    end

    // sequencer and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= SEQ_IDLE;
            axis_reg   <= '0;
            cnt_reg    <= '0;
            level_reg  <= '0;
            state_reg  <= ST_IDLE;
            start_reg  <= '0;
            cd_end_reg <= '0;
        end
        else
        begin
            case (seq_reg)
                SEQ_IDLE:
                begin
                    if (q_valid)
                    begin
                        axis_reg <= '0;
                        seq_reg  <= q_first ? SEQ_EVAL : SEQ_SQ;
                    end
                end
                SEQ_SQ:
                begin
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        cnt_reg <= ROOT_LAST;
                        seq_reg <= SEQ_ROOT;
                    end
                end
                SEQ_ROOT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        seq_reg <= SEQ_LEVEL;
                    end
                end
                SEQ_LEVEL:
                begin
                    level_reg <= lvl_sat;
                    seq_reg   <= SEQ_EVAL;
                end
                SEQ_EVAL:
                begin
                    if (out_free)
                    begin
                        level_reg <= lvl_new;
                        state_reg <= st_new;
                        if (go_detect)
                        begin
                            start_reg <= time_reg;
                        end
                        if (go_trigger)
                        begin
                            cd_end_reg <= time_reg + TIME_BITS'(cooldown_reg);
                        end
                        seq_reg <= SEQ_IDLE;
                    end
                end
                default:
                begin
                    seq_reg <= SEQ_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dx_reg   <= q_dx;
            dy_reg   <= q_dy;
            dz_reg   <= q_dz;
            time_reg <= q_time;
            app_reg  <= q_app;
            prod_reg <= PW'(level_reg) * PW'(decay_reg);
            acc_reg  <= '0;
        end
        if (seq_reg == SEQ_SQ)
        begin
            acc_reg <= acc_next;
            if (axis_reg == 2'd2)
            begin
                rad_reg  <= acc_next;
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        if (seq_reg == SEQ_ROOT)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? (RW+2)'(rem_t - trial) : (RW+2)'(rem_t);
            root_reg <= {root_reg[RW-2:0], take};
        end
        if (load)
        begin
            out_state_reg <= st_new;
            out_pulse_reg <= pulse;
            out_level_reg <= lvl_new;
            out_cool_reg  <= cool;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_cool_reg, out_level_reg, out_pulse_reg, out_state_reg});

    // checks
    a_pulse_triggered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pulse_reg) |-> (out_state_reg == ST_TRIGGERED
                                            && out_level_reg == '0))
        else $error("trigger pulse without triggered state and cleared level");

    a_cool_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cool_reg) |-> (out_state_reg == ST_IDLE && !out_pulse_reg))
        else $error("cooldown result not idle");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_ROOT || seq_reg == SEQ_SQ) |-> !q_pop)
        else $error("queue popped while an item is in progress");

    a_trigger_sets_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && go_trigger) |=> (cd_end_reg == $past(time_reg) + TIME_BITS'($past(cooldown_reg))))
        else $error("cooldown end not taken on trigger");

endmodule

[design/imu_shake_detector_core.sv]
// top level of the imu shake detector: front end, queue, back end
// sequencing: the first sample after reset goes straight to evaluation, every
//   later sample passes the square, root, level and evaluation steps
// the back end sequencer takes a new item only when idle and works through it in steps
//   (three square steps on one multiplier, then one root bit per cycle)
// reset: rst_n asynchronous active low, clears state and sets registers to defaults
`timescale 1ns / 1ps

module imu_shake_detector_core #(
    parameter int ACCEL_BITS = 16,
    parameter int LEVEL_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // accel_x, accel_y, accel_z, time_ms, app_shaked, zero pad
    input  logic [((3*ACCEL_BITS+33+7)/8)*8-1:0] s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // shake_state, trigger_pulse, intensity, in_cooldown, zero pad
    output logic [((LEVEL_BITS+4+7)/8)*8-1:0]  m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [isd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [isd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import isd_pkg::*;

    localparam int IN_W  = ((3*ACCEL_BITS+33+7)/8)*8;
    localparam int OUT_W = ((LEVEL_BITS+4+7)/8)*8;
    localparam int Q_W   = 3*(ACCEL_BITS+1) + TIME_BITS + 2;

    logic           q_push;
    logic [Q_W-1:0] q_wr_data;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    logic [Q_W-1:0] q_rd_data;
    cfg_wr_t        cfg;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    isd_front #(
        .ACCEL_BITS (ACCEL_BITS),
        .IN_W       (IN_W),
        .Q_W        (Q_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    isd_fifo #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    isd_back #(
        .ACCEL_BITS (ACCEL_BITS),
        .LEVEL_BITS (LEVEL_BITS),
        .Q_W        (Q_W),
        .OUT_W      (OUT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_data   (q_rd_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
